// ===== design/slr_pkg.sv =====
package slr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SAMPLE_W      = 16;
    localparam int STEP_W        = 20;
    localparam int MAX_OUT       = 16;
    localparam int CNT_W         = $clog2(MAX_OUT);
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;
    localparam logic              PASS_RESET = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_L,
        S_MUL_R,
        S_FIN
    } state_t;

endpackage

// ===== design/slr_mul_unit.sv =====
module slr_mul_unit
    import slr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] base,
    input  logic signed [SAMPLE_W:0]   diff,
    input  logic [FRAC_BITS-1:0]       phase_frac,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int SUM_W = FRAC_BITS + SAMPLE_W + 2;
    localparam logic [SUM_W-1:0] BIAS = {{(SAMPLE_W + 2){1'b0}}, {FRAC_BITS{1'b1}}};

    logic signed [SAMPLE_W-1:0] base_reg;
    logic signed [SUM_W-1:0]    prod_reg;
    logic signed [SUM_W-1:0]    prod_next;
    logic signed [SUM_W-1:0]    base_ext;
    logic signed [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]           sum_adj;

    assign prod_next = diff * $signed({1'b0, phase_frac});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            base_reg <= base;
            prod_reg <= prod_next;
        end
    end

    assign base_ext = {{2{base_reg[SAMPLE_W-1]}}, base_reg, {FRAC_BITS{1'b0}}};
    assign sum      = base_ext + prod_reg;

    // Negative sums are biased so that the shift truncates toward zero.
    assign sum_adj  = sum[SUM_W-1] ? (sum + BIAS) : sum;
    assign result   = sum_adj[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];

endmodule

// ===== design/stereo_linear_resampler_top.sv =====
// A pass-through frame goes from idle straight to the final step, which registers its beat.
// An interpolated frame steps through left multiply, right multiply and the final step for
// each output beat, as the one shared multiplier works the left and then the right channel.
// A frame that causes no output is taken in idle. Output stall holds the final step.
// Reset clears the phase, the held frame and all valid flags; step is 65536, pass-through on.
module stereo_linear_resampler_top
    import slr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [STEP_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] in_left,
    input  logic signed [SAMPLE_W-1:0] in_right,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       last_of_run
);

    localparam int PHASE_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
    localparam logic [PHASE_W-1:0] ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

    state_t state_reg, state_next;

    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       pass_reg, pass_next;
    logic [PHASE_W-1:0]         phase_reg, phase_next;
    logic signed [SAMPLE_W-1:0] held_left_reg, held_left_next;
    logic signed [SAMPLE_W-1:0] held_right_reg, held_right_next;
    logic signed [SAMPLE_W-1:0] b_left_reg, b_left_next;
    logic signed [SAMPLE_W-1:0] b_right_reg, b_right_next;
    logic signed [SAMPLE_W-1:0] left_res_reg, left_res_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_left_next;
    logic signed [SAMPLE_W-1:0] out_right_reg, out_right_next;
    logic                       last_reg, last_next;

    logic                       in_beat;
    logic                       cfg_beat;
    logic                       out_free;
    logic                       out_load;
    logic                       unit_load;
    logic                       unit_right;
    logic [PHASE_W-1:0]         phase_adv;
    logic                       run_done;
    logic signed [SAMPLE_W-1:0] unit_base;
    logic signed [SAMPLE_W:0]   unit_diff;
    logic signed [SAMPLE_W-1:0] unit_result;

    assign cfg_ready = 1'b1;
    assign cfg_beat  = cfg_valid && cfg_ready;
    assign in_beat   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign phase_adv = phase_reg + PHASE_W'(step_reg);
    assign run_done  = pass_reg || (phase_adv >= ONE) || (cnt_reg == CNT_LAST);

    assign unit_base = unit_right ? held_right_reg : held_left_reg;
    assign unit_diff = unit_right
        ? ((SAMPLE_W+1)'(b_right_reg) - (SAMPLE_W+1)'(held_right_reg))
        : ((SAMPLE_W+1)'(b_left_reg) - (SAMPLE_W+1)'(held_left_reg));

    slr_mul_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk        (clk),
        .load       (unit_load),
        .base       (unit_base),
        .diff       (unit_diff),
        .phase_frac (phase_reg[FRAC_BITS-1:0]),
        .result     (unit_result)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (pass_reg)
                        state_next = S_FIN;
                    else if (phase_reg < ONE)
                        state_next = S_MUL_L;
                end
            end
            S_MUL_L: state_next = S_MUL_R;
            S_MUL_R: state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                    state_next = run_done ? S_IDLE : S_MUL_L;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        unit_load  = 1'b0;
        unit_right = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_MUL_L: unit_load = 1'b1;
            S_MUL_R:
            begin
                unit_load  = 1'b1;
                unit_right = 1'b1;
            end
            S_FIN:   out_load = out_free;
            default: in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next       = step_reg;
        pass_next       = pass_reg;
        phase_next      = phase_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        b_left_next     = b_left_reg;
        b_right_next    = b_right_reg;
        left_res_next   = left_res_reg;
        cnt_next        = cnt_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_beat)
        begin
            if (cfg_index == CFG_STEP_RATIO)
            begin
                step_next       = cfg_data;
                phase_next      = '0;
                held_left_next  = '0;
                held_right_next = '0;
            end
            else if (cfg_index == CFG_PASS_THROUGH)
            begin
                pass_next = cfg_data[0];
            end
        end

        if (in_beat)
        begin
            b_left_next  = in_left;
            b_right_next = in_right;
            cnt_next     = '0;
            if (!pass_reg && (phase_reg >= ONE))
            begin
                phase_next      = phase_reg - ONE;
                held_left_next  = in_left;
                held_right_next = in_right;
            end
        end

        if (state_reg == S_MUL_R)
            left_res_next = unit_result;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            last_next      = run_done;
            out_left_next  = pass_reg ? b_left_reg : left_res_reg;
            out_right_next = pass_reg ? b_right_reg : unit_result;
            if (!pass_reg)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (run_done)
                begin
                    phase_next      = (phase_adv >= ONE) ? (phase_adv - ONE) : '0;
                    held_left_next  = b_left_reg;
                    held_right_next = b_right_reg;
                end
                else
                begin
                    phase_next = phase_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= STEP_RESET;
            pass_reg       <= PASS_RESET;
            phase_reg      <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            pass_reg       <= pass_next;
            phase_reg      <= phase_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_left_reg    <= b_left_next;
        b_right_reg   <= b_right_next;
        left_res_reg  <= left_res_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_left    = out_left_reg;
    assign out_right   = out_right_reg;
    assign last_of_run = last_reg;

    // The multiplier is only started while the phase is below one.
    a_phase_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_L) |-> (phase_reg < ONE))
        else $error("interpolation started with phase at or above one");

    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_L) |=> (state_reg == S_MUL_R))
        else $error("right channel multiply did not follow left");

    a_pass_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && pass_reg) |=> (state_reg == S_FIN))
        else $error("pass-through frame did not go straight to output");

    a_beat_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("output beat raised outside the final step");

endmodule

// ===== tb/tb_stereo_linear_resampler_top.sv =====
`timescale 1ns / 100ps

module tb_stereo_linear_resampler_top;
    import slr_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int PH_W = STEP_W + 2;
    localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_FRAMES = 310;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t left;
        sample_t right;
        logic    last;
    } beat_t;

    typedef enum logic {
        ROW_FRAME,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [STEP_W-1:0]    data;
        sample_t              left;
        sample_t              right;
        logic                 typed;
        sample_t              exp_left;
        sample_t              exp_right;
    } dir_row_t;

    localparam int DIR_ROWS = 33;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
        '{ROW_FRAME, '0, '0, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
        '{ROW_FRAME, '0, '0, 16'shFFFF, 16'sh0001, 1'b1, 16'shFFFF, 16'sh0001},
        '{ROW_REG, CFG_PASS_THROUGH, 20'h00000, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh04D2, 16'shEF1F, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'd32768, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh8000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'd0, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh1388, 16'shEC78, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'd1000, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh0064, 16'sh00C8, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'shFF9C, 16'shFF38, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh8000, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'd4096, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_REG, CFG_STEP_RATIO, 20'd100000, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh0000, 16'sh0000, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
        '{ROW_REG, CFG_PASS_THROUGH, 20'hFFFFF, '0, '0, 1'b0, '0, '0},
        '{ROW_FRAME, '0, '0, 16'sh3039, 16'shCFC7, 1'b1, 16'sh3039, 16'shCFC7},
        '{ROW_FRAME, '0, '0, 16'sh8000, 16'sh8000, 1'b1, 16'sh8000, 16'sh8000}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [STEP_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    sample_t              in_left = '0;
    sample_t              in_right = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    sample_t              out_left;
    sample_t              out_right;
    logic                 last_of_run;

    logic [STEP_W-1:0] step_q;
    logic              pass_q;
    logic [PH_W-1:0]   phase_q;
    sample_t           held_left_q;
    sample_t           held_right_q;

    beat_t pending_beats [$];
    int    mismatches = 0;
    bit    calm = 1'b0;
    int    stall_left = 0;

    stereo_linear_resampler_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_left    (in_left),
        .in_right   (in_right),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_left   (out_left),
        .out_right  (out_right),
        .last_of_run(last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t blend(sample_t a, sample_t b, logic [PH_W-1:0] ph);
        longint v;
        longint q;
        v = longint'(a) * (longint'(1) << FRAC) + (longint'(b) - longint'(a)) * longint'(ph);
        if (v >= 0)
        begin
            q = v >>> FRAC;
        end
        else
        begin
            q = -((-v) >>> FRAC);
        end
        return sample_t'(q);
    endfunction

    task automatic resample_frame(input sample_t l, input sample_t r);
        beat_t b;
        int n;
        if (pass_q)
        begin
            b = '{l, r, 1'b1};
            pending_beats.push_back(b);
            return;
        end
        n = 0;
        while (phase_q < ONE && n < MAX_OUT)
        begin
            b.left = blend(held_left_q, l, phase_q);
            b.right = blend(held_right_q, r, phase_q);
            phase_q = phase_q + PH_W'(step_q);
            n++;
            b.last = !(phase_q < ONE && n < MAX_OUT);
            pending_beats.push_back(b);
        end
        phase_q = (phase_q >= ONE) ? phase_q - ONE : '0;
        held_left_q = l;
        held_right_q = r;
    endtask

    task automatic note_mismatch(input string what, input beat_t want, input beat_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                     $realtime, what, want.left, want.right, want.last,
                     got.left, got.right, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{out_left, out_right, last_of_run};
            if (pending_beats.size() == 0)
            begin
                note_mismatch("unexpected beat", '0, got);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got.left !== want.left || got.right !== want.right
                    || got.last !== want.last)
                begin
                    note_mismatch("beat mismatch", want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        logic hold;
        hold = out_stall;
        if (stall_left > 0)
        begin
            stall_left--;
        end
        else if (calm)
        begin
            hold = 1'b0;
            stall_left = $urandom_range(0, 8);
        end
        else
        begin
            hold = ($urandom_range(0, 2) == 0);
            stall_left = pick_gap();
        end
        out_stall <= hold;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_STEP_RATIO)
        begin
            step_q = data;
            phase_q = '0;
            held_left_q = '0;
            held_right_q = '0;
        end
        else if (idx == CFG_PASS_THROUGH)
        begin
            pass_q = data[0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input sample_t l, input sample_t r, input bit use_model,
                              input beat_t fixed);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_left <= l;
        in_right <= r;
        do @(posedge clk); while (in_stall);
        if (use_model)
        begin
            resample_frame(l, r);
        end
        else
        begin
            pending_beats.push_back(fixed);
        end
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return '0;
        end
        else if (r < 14)
        begin
            return STEP_W'($urandom_range(1, 4095));
        end
        else if (r < 20)
        begin
            return STEP_W'(4096);
        end
        else if (r < 26)
        begin
            return STEP_W'(524288);
        end
        else if (r < 30)
        begin
            return '1;
        end
        else if (r < 36)
        begin
            return STEP_W'($urandom);
        end
        return STEP_W'($urandom_range(16384, 131072));
    endfunction

    function automatic logic [STEP_W-1:0] pass_word();
        logic [STEP_W-1:0] w;
        w = STEP_W'($urandom);
        w[0] = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    function automatic sample_t pick_sample(sample_t prev);
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        else if (r < 35)
        begin
            d = $urandom_range(0, 200);
            return prev + sample_t'(d - 100);
        end
        return sample_t'($urandom);
    endfunction

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        beat_t fixed;
        sample_t l;
        sample_t r;
        sample_t prev_l;
        sample_t prev_r;
        int frames_left;
        int burst;

        step_q = STEP_RESET;
        pass_q = PASS_RESET;
        phase_q = '0;
        held_left_q = '0;
        held_right_q = '0;
        prev_l = '0;
        prev_r = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIR_TABLE[i];
            if (row.kind == ROW_REG)
            begin
                settle_idle();
                write_reg(row.index, row.data);
            end
            else
            begin
                fixed = '{row.exp_left, row.exp_right, 1'b1};
                send_frame(row.left, row.right, !row.typed, fixed);
            end
        end

        frames_left = RANDOM_FRAMES;
        while (frames_left > 0)
        begin
            settle_idle();
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: write_reg(CFG_STEP_RATIO, pick_step());
                1: write_reg(CFG_PASS_THROUGH, pass_word());
                2:
                begin
                    write_reg(CFG_STEP_RATIO, pick_step());
                    write_reg(CFG_PASS_THROUGH, pass_word());
                end
                default:
                begin
                    write_reg(CFG_PASS_THROUGH, pass_word());
                    write_reg(CFG_STEP_RATIO, pick_step());
                end
            endcase
            burst = $urandom_range(8, 40);
            if (burst > frames_left)
            begin
                burst = frames_left;
            end
            repeat (burst)
            begin
                l = pick_sample(prev_l);
                r = pick_sample(prev_r);
                send_frame(l, r, 1'b1, '0);
                prev_l = l;
                prev_r = r;
            end
            frames_left -= burst;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_beats.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
